// File: design/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

    localparam int unsigned BITS_PER_ROW_DEF = 64;
    localparam int unsigned ROW_COUNT_DEF    = 1024;
    localparam int unsigned PAGE_SHIFT_DEF   = 12;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned LIMIT_W  = 33;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 33'h1_0000_0000;

endpackage

// File: design/bpfa_bitmap_ram.sv
`timescale 1ns / 1ps

module bpfa_bitmap_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/bpfa_page_split.sv
`timescale 1ns / 1ps

// splits a page number into row and column, reciprocal multiply plus one correction
module bpfa_page_split #(
    parameter int unsigned BITS_PER_ROW = 64,
    parameter int unsigned ROW_COUNT    = 1024,
    localparam int unsigned TOTAL = BITS_PER_ROW * ROW_COUNT,
    localparam int unsigned PG_W  = $clog2(TOTAL),
    localparam int unsigned ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1,
    localparam int unsigned COL_W = $clog2(BITS_PER_ROW)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [PG_W-1:0]  i_page,
    output logic             o_valid,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col
);

    // floor(2^PG_W / BITS_PER_ROW): estimate is the true quotient or one less
    localparam int unsigned RECIP = (1 << PG_W) / BITS_PER_ROW;

    logic [2*PG_W-1:0] w_prod;
    logic [PG_W-1:0]   w_rem;

    logic             r_v1, r_v2, r_v3;
    logic [ROW_W-1:0] r_s1_q, r_s2_q, r_row;
    logic [PG_W-1:0]  r_s1_page, r_s2_page, r_s2_sub;
    logic [COL_W-1:0] r_col;

    assign w_prod = (2*PG_W)'(i_page) * (2*PG_W)'(RECIP);
    assign w_rem  = r_s2_page - r_s2_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_q    <= ROW_W'(w_prod[2*PG_W-1:PG_W]);
        r_s1_page <= i_page;
        r_s2_q    <= r_s1_q;
        r_s2_page <= r_s1_page;
        r_s2_sub  <= PG_W'(PG_W'(r_s1_q) * PG_W'(BITS_PER_ROW));
        if (w_rem >= PG_W'(BITS_PER_ROW)) begin
            r_row <= ROW_W'(r_s2_q + 1'b1);
            r_col <= COL_W'(w_rem - PG_W'(BITS_PER_ROW));
        end else begin
            r_row <= r_s2_q;
            r_col <= COL_W'(w_rem);
        end
    end

    assign o_valid = r_v3;
    assign o_row   = r_row;
    assign o_col   = r_col;

endmodule

// File: design/bitmap_page_frame_allocator_top.sv
`timescale 1ns / 1ps

// one request at a time; an allocate reads rows from the hint pointer until one has room (no
// page if none has), a free splits the page and clears its bit, a reserve splits both ends and
// sets bits row by row; an out-of-range, empty or unknown request goes straight to the result; the next request is
// taken the cycle after the word is loaded, later while the output word is stalled
// synchronous active-low reset starts a clearing pass that writes zero to every bitmap row;
// no request is taken until it ends, limit writes are taken once reset is released
module bitmap_page_frame_allocator_top #(
    parameter int unsigned BITS_PER_ROW = bpfa_pkg::BITS_PER_ROW_DEF,
    parameter int unsigned ROW_COUNT    = bpfa_pkg::ROW_COUNT_DEF,
    parameter int unsigned PAGE_SHIFT   = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // phys_addr [31:0], range_bytes [63:32]
    input  logic [1:0]  s_axis_tuser,  // mode [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // page_addr [31:0]
    output logic [1:0]  m_axis_tuser,  // status [1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [32:0] i_cfg_data     // alloc_limit_addr
);

    import bpfa_pkg::*;

    localparam int unsigned TOTAL  = BITS_PER_ROW * ROW_COUNT;
    localparam int unsigned PG_W   = $clog2(TOTAL);
    localparam int unsigned ROW_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int unsigned HINT_W = $clog2(ROW_COUNT + 1);
    localparam int unsigned COL_W  = $clog2(BITS_PER_ROW);
    localparam int unsigned P_W    = ADDR_W - PAGE_SHIFT;
    localparam int unsigned CNT_W  = ADDR_W + 1 - PAGE_SHIFT;
    localparam int unsigned CMP_W  = (PG_W + PAGE_SHIFT > 34) ? PG_W + PAGE_SHIFT : 34;
    localparam logic [ADDR_W:0] PAGE_MASK = (ADDR_W + 1)'((1 << PAGE_SHIFT) - 1);

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_DISP   = 15'b000000000000100,
        S_A_RD   = 15'b000000000001000,
        S_A_CHK  = 15'b000000000010000,
        S_A_ADDR = 15'b000000000100000,
        S_A_DEC  = 15'b000000001000000,
        S_F_DIV  = 15'b000000010000000,
        S_F_RD   = 15'b000000100000000,
        S_F_MOD  = 15'b000001000000000,
        S_R_DIVL = 15'b000010000000000,
        S_R_DIVH = 15'b000100000000000,
        S_R_RD   = 15'b001000000000000,
        S_R_MOD  = 15'b010000000000000,
        S_RESP   = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]  r_limit;
    logic [HINT_W-1:0]   r_hint, n_hint;
    logic [ROW_W-1:0]    r_clr, n_clr;
    logic                r_out_valid, n_out_valid;
    logic                r_div_go, n_div_go;

    logic [MODE_W-1:0]   r_mode;
    logic [P_W-1:0]      r_page;
    logic [CNT_W-1:0]    r_count;
    logic [ROW_W-1:0]    r_cur, n_cur;
    logic [ROW_W-1:0]    r_row_lo, n_row_lo;
    logic [ROW_W-1:0]    r_row_hi, n_row_hi;
    logic [COL_W-1:0]    r_clo, n_clo;
    logic [COL_W-1:0]    r_chi, n_chi;
    logic [PG_W-1:0]     r_pg, n_pg;
    logic [PG_W-1:0]     r_div_page, n_div_page;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic [STATUS_W-1:0] r_out_status;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                w_load_out;

    logic                    ram_we, ram_re;
    logic [ROW_W-1:0]        ram_waddr, ram_raddr;
    logic [BITS_PER_ROW-1:0] ram_wdata, ram_rdata;

    logic                    div_valid;
    logic [ROW_W-1:0]        div_row;
    logic [COL_W-1:0]        div_col;

    logic                    w_full;
    logic [COL_W-1:0]        w_free_col;
    logic [BITS_PER_ROW-1:0] w_bit, w_mask;
    logic [COL_W-1:0]        w_clo_eff, w_chi_eff;
    logic [CMP_W-1:0]        w_addr;
    logic                    w_alloc_fault;
    logic                    w_accept;

    bpfa_bitmap_ram #(
        .WIDTH (BITS_PER_ROW),
        .DEPTH (ROW_COUNT),
        .AW    (ROW_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpfa_page_split #(
        .BITS_PER_ROW (BITS_PER_ROW),
        .ROW_COUNT    (ROW_COUNT)
    ) u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_div_go),
        .i_page  (r_div_page),
        .o_valid (div_valid),
        .o_row   (div_row),
        .o_col   (div_col)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_addr;
    assign m_axis_tuser  = r_out_status;

    // column 0 sits in the top bit of a row
    always_comb begin
        w_full     = &ram_rdata;
        w_free_col = '0;
        for (int c = BITS_PER_ROW - 1; c >= 0; c--) begin
            if (!ram_rdata[BITS_PER_ROW-1-c]) begin
                w_free_col = COL_W'(c);
            end
        end
    end

    assign w_bit = BITS_PER_ROW'(1) << (COL_W'(BITS_PER_ROW - 1) - r_clo);

    assign w_clo_eff = (r_cur == r_row_lo) ? r_clo : '0;
    assign w_chi_eff = (r_cur == r_row_hi) ? r_chi : COL_W'(BITS_PER_ROW - 1);

    always_comb begin
        w_mask = '0;
        for (int b = 0; b < BITS_PER_ROW; b++) begin
            if (COL_W'(BITS_PER_ROW - 1 - b) >= w_clo_eff &&
                COL_W'(BITS_PER_ROW - 1 - b) <= w_chi_eff) begin
                w_mask[b] = 1'b1;
            end
        end
    end

    assign w_addr        = CMP_W'(r_pg) << PAGE_SHIFT;
    assign w_alloc_fault = (r_pg == '0) || (w_addr >= CMP_W'(r_limit)) ||
                           (|w_addr[CMP_W-1:ADDR_W]);

    always_comb begin
        n_state      = r_state;
        n_hint       = r_hint;
        n_clr        = r_clr;
        n_div_go     = 1'b0;
        n_div_page   = r_div_page;
        n_cur        = r_cur;
        n_row_lo     = r_row_lo;
        n_row_hi     = r_row_hi;
        n_clo        = r_clo;
        n_chi        = r_chi;
        n_pg         = r_pg;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        ram_we       = 1'b0;
        ram_waddr    = r_cur;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_cur;
        w_load_out   = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                if (r_clr == ROW_W'(ROW_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = ROW_W'(r_clr + 1'b1);
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_res_status = ST_OK;
                n_res_addr   = '0;
                unique case (r_mode)
                    MODE_ALLOC: begin
                        n_state = S_A_RD;
                    end
                    MODE_FREE: begin
                        if (34'(r_page) >= 34'(TOTAL)) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            n_div_go   = 1'b1;
                            n_div_page = PG_W'(r_page);
                            n_state    = S_F_DIV;
                        end
                    end
                    MODE_RESERVE: begin
                        if (r_count == '0) begin
                            n_state = S_RESP;
                        end else if (34'(r_page) + 34'(r_count) > 34'(TOTAL)) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            n_div_go   = 1'b1;
                            n_div_page = PG_W'(r_page);
                            n_state    = S_R_DIVL;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_A_RD: begin
                if (r_hint == HINT_W'(ROW_COUNT)) begin
                    n_res_status = ST_NO_PAGE;
                    n_state      = S_RESP;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = ROW_W'(r_hint);
                    n_state   = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (w_full) begin
                    // rows below the pointer are all full
                    n_hint  = HINT_W'(r_hint + 1'b1);
                    n_state = S_A_RD;
                end else begin
                    n_clo   = w_free_col;
                    n_state = S_A_ADDR;
                end
            end
            S_A_ADDR: begin
                n_pg    = PG_W'(PG_W'(r_hint) * PG_W'(BITS_PER_ROW)) + PG_W'(r_clo);
                n_state = S_A_DEC;
            end
            S_A_DEC: begin
                if (w_alloc_fault) begin
                    n_res_status = ST_NO_PAGE;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = ROW_W'(r_hint);
                    ram_wdata  = ram_rdata | w_bit;
                    n_res_addr = w_addr[ADDR_W-1:0];
                end
                n_state = S_RESP;
            end
            S_F_DIV: begin
                if (div_valid) begin
                    n_cur   = div_row;
                    n_clo   = div_col;
                    n_state = S_F_RD;
                end
            end
            S_F_RD: begin
                ram_re  = 1'b1;
                n_state = S_F_MOD;
            end
            S_F_MOD: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata & ~w_bit;
                if (HINT_W'(r_cur) < r_hint) begin
                    n_hint = HINT_W'(r_cur);
                end
                n_state = S_RESP;
            end
            S_R_DIVL: begin
                if (div_valid) begin
                    n_cur      = div_row;
                    n_row_lo   = div_row;
                    n_clo      = div_col;
                    n_div_go   = 1'b1;
                    n_div_page = PG_W'(34'(r_page) + 34'(r_count) - 34'd1);
                    n_state    = S_R_DIVH;
                end
            end
            S_R_DIVH: begin
                if (div_valid) begin
                    n_row_hi = div_row;
                    n_chi    = div_col;
                    n_state  = S_R_RD;
                end
            end
            S_R_RD: begin
                ram_re  = 1'b1;
                n_state = S_R_MOD;
            end
            S_R_MOD: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | w_mask;
                if (r_cur == r_row_hi) begin
                    n_state = S_RESP;
                end else begin
                    n_cur   = ROW_W'(r_cur + 1'b1);
                    n_state = S_R_RD;
                end
            end
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = w_load_out || (r_out_valid && !m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_hint      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
            r_div_go    <= n_div_go;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode  <= s_axis_tuser;
            r_page  <= s_axis_tdata[ADDR_W-1:PAGE_SHIFT];
            r_count <= CNT_W'(((ADDR_W + 1)'(s_axis_tdata[63:32]) + PAGE_MASK) >> PAGE_SHIFT);
        end
        r_cur        <= n_cur;
        r_row_lo     <= n_row_lo;
        r_row_hi     <= n_row_hi;
        r_clo        <= n_clo;
        r_chi        <= n_chi;
        r_pg         <= n_pg;
        r_div_page   <= n_div_page;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
        end
    end

endmodule

// File: design/bpfa_checker.sv
`timescale 1ns / 1ps

module bpfa_checker #(
    parameter int unsigned PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    import bpfa_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_NO_PAGE ||
                           m_axis_tuser == ST_RANGE))
        else $error("unknown status code");

    // faults never carry an address, and addresses are page aligned
    a_fault_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
        else $error("address on a faulted request");

    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[PAGE_SHIFT-1:0] == '0)
        else $error("page address not aligned");

    // clearing pass follows reset, so no request is taken straight after it
    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !s_axis_tready)
        else $error("request taken before bitmap cleared");

endmodule

bind bitmap_page_frame_allocator_top bpfa_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
) u_bpfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/tb_bitmap_page_frame_allocator_top.sv
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_top;
    import bpfa_pkg::*;

    localparam int unsigned ROW_BITS = BITS_PER_ROW_DEF;
    localparam int unsigned ROWS     = ROW_COUNT_DEF;
    localparam int unsigned SHIFT    = PAGE_SHIFT_DEF;
    localparam longint unsigned PAGE_TOTAL = ROW_BITS * ROWS;

    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
    localparam int unsigned PHASE_ITEMS = 265;
    localparam int unsigned HOLD_CYCLES = 300;

    // tracks the used/free bitmap and the result words still owed by the block
    class page_map_tracker;
        bit   [ROW_BITS-1:0] used_rows [ROWS];
        bit   [LIMIT_W-1:0]  alloc_limit;
        logic [STATUS_W-1:0] status_due [$];
        logic [ADDR_W-1:0]   addr_due [$];
        int unsigned         mismatches;

        function new();
            foreach (used_rows[r]) used_rows[r] = '0;
            alloc_limit = LIMIT_RESET;
            mismatches  = 0;
        endfunction

        function int unsigned outstanding();
            return status_due.size();
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            alloc_limit = value;
        endfunction

        function void note_mismatch(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s", $time, what);
            end
        endfunction

        function void take_request(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] paddr,
                                   logic [ADDR_W-1:0] len);
            logic [STATUS_W-1:0] st;
            logic [ADDR_W-1:0]   got_addr;
            longint unsigned     page, count, byte_addr, p;
            int unsigned         r, c;
            st       = ST_OK;
            got_addr = '0;
            case (mode)
                MODE_ALLOC: begin
                    r = 0;
                    c = 0;
                    while (r < ROWS && used_rows[r] == '1) r++;
                    if (r == ROWS) begin
                        page = PAGE_TOTAL;
                    end else begin
                        // column 0 sits in the top bit of the row
                        while (used_rows[r][ROW_BITS-1-c]) c++;
                        page = r * ROW_BITS + c;
                    end
                    byte_addr = page << SHIFT;
                    if (page >= PAGE_TOTAL || page == 0 || byte_addr >= alloc_limit
                            || byte_addr > 64'hFFFF_FFFF) begin
                        st = ST_NO_PAGE;
                    end else begin
                        used_rows[r][ROW_BITS-1-c] = 1'b1;
                        got_addr = byte_addr[ADDR_W-1:0];
                    end
                end
                MODE_FREE: begin
                    page = paddr >> SHIFT;
                    if (page >= PAGE_TOTAL) begin
                        st = ST_RANGE;
                    end else begin
                        used_rows[page / ROW_BITS][ROW_BITS-1-(page % ROW_BITS)] = 1'b0;
                    end
                end
                MODE_RESERVE: begin
                    page  = paddr >> SHIFT;
                    count = len;
                    count = (count + (64'd1 << SHIFT) - 1) >> SHIFT;
                    if (count != 0) begin
                        if (page + count > PAGE_TOTAL) begin
                            st = ST_RANGE;
                        end else begin
                            for (p = page; p < page + count; p++) begin
                                used_rows[p / ROW_BITS][ROW_BITS-1-(p % ROW_BITS)] = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            status_due.push_back(st);
            addr_due.push_back(got_addr);
        endfunction

        function void match_result(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] pa);
            logic [STATUS_W-1:0] want_st;
            logic [ADDR_W-1:0]   want_pa;
            if (status_due.size() == 0) begin
                note_mismatch($sformatf("result word with no request waiting: status %0d addr %h",
                                        st, pa));
                return;
            end
            want_st = status_due.pop_front();
            want_pa = addr_due.pop_front();
            if (st !== want_st || pa !== want_pa) begin
                note_mismatch($sformatf("status exp %0d got %0d, page_addr exp %h got %h",
                                        want_st, st, want_pa, pa));
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [63:0]         s_axis_tdata;  // phys_addr [31:0], range_bytes [63:32]
    logic [1:0]          s_axis_tuser;  // mode [1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [31:0]         m_axis_tdata;  // page_addr [31:0]
    logic [1:0]          m_axis_tuser;  // status [1:0]
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_data;

    page_map_tracker tracker;
    int unsigned     burst_left;

    bitmap_page_frame_allocator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                tracker.match_result(m_axis_tuser, m_axis_tdata);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                tracker.take_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
            end
        end
    end

    // result side: segments of varying stall density, plus a long hold-off now and then
    initial begin : result_sink
        int unsigned seg_left, stall_pct, taken, next_hold;
        seg_left      = 0;
        stall_pct     = 0;
        taken         = 0;
        next_hold     = 40;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) taken++;
            if (taken >= next_hold) begin
                next_hold += 500;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 64);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            seg_left--;
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] paddr,
                                input logic [ADDR_W-1:0] len);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {len, paddr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(0, 16);
        end else begin
            burst_left--;
        end
    endtask

    task automatic random_request();
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] paddr, len;
        int unsigned       pick, sub;
        pick  = $urandom_range(0, 99);
        sub   = $urandom_range(0, 19);
        paddr = $urandom;
        len   = $urandom;
        if (pick < 38) begin
            mode = MODE_ALLOC;
        end else if (pick < 68) begin
            mode = MODE_FREE;
            // mostly the low rows, so allocations keep finding holes near the bottom
            if (sub == 1) begin
                paddr = $urandom_range(0, 4095);
            end else if (sub >= 2 && sub < 7) begin
                paddr = $urandom_range(0, 32'h0FFF_FFFF);
            end else if (sub >= 7) begin
                paddr = $urandom_range(0, 32'h001F_FFFF);
            end
        end else if (pick < 93) begin
            mode = MODE_RESERVE;
            if (sub == 2) begin
                paddr = $urandom_range(0, 4095);
                len   = $urandom_range(1, 32'h3000);
            end else if (sub > 2) begin
                paddr = $urandom_range(0, 32'h001F_FFFF);
                if (sub < 5) begin
                    len = '0;
                end else if (sub < 8) begin
                    len = $urandom_range(1, 32'h0040_0000);
                end else begin
                    len = $urandom_range(1, 32'h8000);
                end
            end
        end else begin
            mode = MODE_UNKNOWN;
        end
        send_request(mode, paddr, len);
    endtask

    // let the current edge pass first so the word accepted at it is already on the books
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.set_limit(value);
    endtask

    initial begin : stimulus
        logic [LIMIT_W-1:0] phase_limits [6];
        logic [LIMIT_W-1:0] rand_limit;
        tracker       = new();
        burst_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ALLOC;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // bitmap empty, limit at its reset value
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_FREE, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_FREE, 32'h0000_0000, 32'h0);
        send_request(MODE_RESERVE, 32'h0FFF_F000, 32'h0000_2000);
        send_request(MODE_RESERVE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(MODE_RESERVE, 32'h1234_5678, 32'h0);
        send_request(MODE_RESERVE, 32'h0000_0000, 32'h0000_0001);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_RESERVE, 32'h0FFF_FFFF, 32'h0000_0001);
        send_request(MODE_RESERVE, 32'h0000_3FFF, 32'h0000_4001);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_FREE, 32'h0000_2ABC, 32'h0);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        // page zero free again: allocation must refuse it
        send_request(MODE_FREE, 32'h0000_0000, 32'h0);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        // whole bitmap used
        send_request(MODE_RESERVE, 32'h0000_0000, 32'h1000_0000);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_FREE, 32'h0ABC_D123, 32'h0);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        send_request(MODE_FREE, 32'h1000_0000, 32'h0);
        send_request(MODE_FREE, 32'h0FFF_F000, 32'h0);
        // last page exactly at the limit, then just below it
        settle();
        write_limit(33'h0_0FFF_F000);
        send_request(MODE_ALLOC, 32'h0, 32'h0);
        settle();
        write_limit(33'h0_0FFF_F001);
        send_request(MODE_ALLOC, 32'h0, 32'h0);

        rand_limit      = LIMIT_W'($urandom);
        rand_limit[32]  = 1'($urandom_range(0, 1));
        phase_limits[0] = LIMIT_RESET;
        phase_limits[1] = '0;
        phase_limits[2] = 33'h1_FFFF_FFFF;
        phase_limits[3] = 33'h0_0004_0000;
        phase_limits[4] = rand_limit;
        phase_limits[5] = 33'h0_0000_1001;
        foreach (phase_limits[i]) begin
            settle();
            write_limit(phase_limits[i]);
            repeat (PHASE_ITEMS) random_request();
        end

        settle();
        repeat (100) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("tb_bitmap_page_frame_allocator_top passed");
        end else begin
            $display("tb_bitmap_page_frame_allocator_top failed");
        end
        $finish;
    end

    initial begin : watchdog
        #250_000_000;
        $display("tb_bitmap_page_frame_allocator_top failed");
        $finish;
    end

endmodule
